/* rtl/core/sfs_pkg.sv */
`timescale 1ns / 1ps

package sfs_pkg;

  // Field and datapath widths.
  localparam int FRAME_W    = 16;
  localparam int TIME_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int PLAYS_W    = 16;
  localparam int PROD_W     = GAIN_W + TIME_W;
  localparam int GAIN_FRAC  = 8;
  localparam int ADJ_W      = PROD_W - GAIN_FRAC;
  localparam int DIVIDEND_W = ADJ_W + 1;
  localparam int DIVISOR_W  = TIME_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
  localparam int LEN_W      = FRAME_W + 1;
  localparam int EVENT_W    = 2;
  localparam int STEP_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USED_W = FRAME_W + 1 + EVENT_W + 1;

  // Register reset values.
  localparam logic [TIME_W-1:0]  PERIOD_RESET = 32'd16667;
  localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd256;
  localparam logic [PLAYS_W-1:0] PLAYS_RESET  = 16'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_FRAME  = 3'd0,
    CFG_END_FRAME    = 3'd1,
    CFG_FRAME_PERIOD = 3'd2,
    CFG_SPEED_GAIN   = 3'd3,
    CFG_PLAY_REVERSE = 3'd4,
    CFG_PLAY_COUNT   = 3'd5,
    CFG_PLAY_FOREVER = 3'd6
  } cfg_index_t;

  // End event codes.
  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 2'd0,
    EV_END   = 2'd1,
    EV_BEGIN = 2'd2
  } end_event_t;

  // Request opcodes.
  localparam logic OPC_TICK    = 1'b0;
  localparam logic OPC_RESTART = 1'b1;

  // Datapath operations driven by the control word.
  typedef enum logic [3:0] {
    OP_NOP        = 4'd0,
    OP_ACCEPT     = 4'd1,
    OP_MUL        = 4'd2,
    OP_SPEND      = 4'd3,
    OP_DIV_PERIOD = 4'd4,
    OP_STEPS      = 4'd5,
    OP_NEAR       = 4'd6,
    OP_DIV_RANGE  = 4'd7,
    OP_WRAP       = 4'd8,
    OP_RESTART    = 4'd9,
    OP_EMIT       = 4'd10
  } op_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER    = 4'd0,
    C_ALWAYS   = 4'd1,
    C_NO_INPUT = 4'd2,
    C_RESTART  = 4'd3,
    C_STOPPED  = 4'd4,
    C_SHORT    = 4'd5,
    C_DIV_BUSY = 4'd6,
    C_NEAR     = 4'd7,
    C_OUT_BUSY = 4'd8
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic no_input;
    logic restart;
    logic stopped;
    logic short_tick;
    logic div_busy;
    logic near;
    logic out_busy;
  } status_t;

  // Program addresses.
  localparam logic [STEP_W-1:0] ST_WAIT       = 4'd0;
  localparam logic [STEP_W-1:0] ST_MUL        = 4'd1;
  localparam logic [STEP_W-1:0] ST_CHECK      = 4'd2;
  localparam logic [STEP_W-1:0] ST_SPEND      = 4'd3;
  localparam logic [STEP_W-1:0] ST_DIV1       = 4'd4;
  localparam logic [STEP_W-1:0] ST_DIV1_WAIT  = 4'd5;
  localparam logic [STEP_W-1:0] ST_STEPS      = 4'd6;
  localparam logic [STEP_W-1:0] ST_NEAR       = 4'd7;
  localparam logic [STEP_W-1:0] ST_DIV2       = 4'd8;
  localparam logic [STEP_W-1:0] ST_DIV2_WAIT  = 4'd9;
  localparam logic [STEP_W-1:0] ST_WRAP       = 4'd10;
  localparam logic [STEP_W-1:0] ST_RESTART    = 4'd11;
  localparam logic [STEP_W-1:0] ST_EMIT       = 4'd15;

  // Control store. A step jumps to target when its condition holds and
  // otherwise falls through to the next address; the last address wraps
  // back to the wait step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      ST_WAIT:      w = '{OP_ACCEPT,     C_NO_INPUT, ST_WAIT};
      ST_MUL:       w = '{OP_MUL,        C_RESTART,  ST_RESTART};
      ST_CHECK:     w = '{OP_NOP,        C_STOPPED,  ST_EMIT};
      ST_SPEND:     w = '{OP_SPEND,      C_SHORT,    ST_EMIT};
      ST_DIV1:      w = '{OP_DIV_PERIOD, C_NEVER,    ST_WAIT};
      ST_DIV1_WAIT: w = '{OP_NOP,        C_DIV_BUSY, ST_DIV1_WAIT};
      ST_STEPS:     w = '{OP_STEPS,      C_NEVER,    ST_WAIT};
      ST_NEAR:      w = '{OP_NEAR,       C_NEAR,     ST_EMIT};
      ST_DIV2:      w = '{OP_DIV_RANGE,  C_NEVER,    ST_WAIT};
      ST_DIV2_WAIT: w = '{OP_NOP,        C_DIV_BUSY, ST_DIV2_WAIT};
      ST_WRAP:      w = '{OP_WRAP,       C_ALWAYS,   ST_EMIT};
      ST_RESTART:   w = '{OP_RESTART,    C_ALWAYS,   ST_EMIT};
      ST_EMIT:      w = '{OP_EMIT,       C_OUT_BUSY, ST_EMIT};
      default:      w = '{OP_NOP,        C_ALWAYS,   ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/sfs_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sfs_div import sfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quo,
  output logic [DIVISOR_W-1:0]  rem
);

  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  divisor_r, divisor_nxt;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  // The divisor is held from the start cycle for the whole divide.
  assign shifted = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, divisor_r};
  assign ge      = shifted >= {1'b0, divisor_r};

  always_comb begin
    cnt_nxt     = cnt_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    if (start) begin
      cnt_nxt     = DIV_CNT_W'(DIVIDEND_W);
      quo_nxt     = dividend;
      rem_nxt     = '0;
      divisor_nxt = divisor;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
      rem_nxt = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  assign busy = cnt_r != '0;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* rtl/core/sfs_seq.sv */
`timescale 1ns / 1ps

// Step counter over the control store with conditional jumps.
module sfs_seq import sfs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output op_t     op
);

  logic [STEP_W-1:0] pc_r, pc_nxt;
  ucode_t            word;
  logic              hit;

  assign word = ucode_rom(pc_r);

  // Select the jump condition named by the control word.
  always_comb begin
    case (word.cond)
      C_NEVER:    hit = 1'b0;
      C_ALWAYS:   hit = 1'b1;
      C_NO_INPUT: hit = status.no_input;
      C_RESTART:  hit = status.restart;
      C_STOPPED:  hit = status.stopped;
      C_SHORT:    hit = status.short_tick;
      C_DIV_BUSY: hit = status.div_busy;
      C_NEAR:     hit = status.near;
      C_OUT_BUSY: hit = status.out_busy;
      default:    hit = 1'b1;
    endcase
    pc_nxt = hit ? word.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op = word.op;

endmodule

/* rtl/core/sprite_frame_sequencer.sv */
`timescale 1ns / 1ps

// A restart, or a tick that arrives while stopped, goes from accept through the multiply step
// to emit; a tick that stays in the current frame also spends its time, one that steps frames
// also divides by the period, and one that wraps divides by the range too; each divide is 41 bits.
// A new request is taken the cycle after the previous result enters the output register,
// so requests are never overlapped, and an output stall holds off the next one.
// Synchronous active-low reset restores the register reset values and the playing state.
module sprite_frame_sequencer import sfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] delta_time
  input  logic                  in_tuser,   // [0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] frame_index, [16] frame_changed, [18:17] end_event, [19] is_playing
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Configuration registers.
  logic [FRAME_W-1:0] start_frame_r, end_frame_r;
  logic [TIME_W-1:0]  frame_period_r;
  logic [GAIN_W-1:0]  speed_gain_r;
  logic               play_reverse_r, play_forever_r;
  logic [PLAYS_W-1:0] play_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_frame_r  <= '0;
      end_frame_r    <= '0;
      frame_period_r <= PERIOD_RESET;
      speed_gain_r   <= GAIN_RESET;
      play_reverse_r <= 1'b0;
      play_count_r   <= PLAYS_RESET;
      play_forever_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_START_FRAME:  start_frame_r  <= cfg_wdata[FRAME_W-1:0];
        CFG_END_FRAME:    end_frame_r    <= cfg_wdata[FRAME_W-1:0];
        CFG_FRAME_PERIOD: frame_period_r <= cfg_wdata[TIME_W-1:0];
        CFG_SPEED_GAIN:   speed_gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_PLAY_REVERSE: play_reverse_r <= cfg_wdata[0];
        CFG_PLAY_COUNT:   play_count_r   <= cfg_wdata[PLAYS_W-1:0];
        CFG_PLAY_FOREVER: play_forever_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer and shared divider.
  op_t                   op;
  status_t               status;
  logic                  div_start, div_busy;
  logic [DIVIDEND_W-1:0] div_quo;
  logic [DIVISOR_W-1:0]  div_rem, div_divisor;

  sfs_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  // Playback state and working registers.
  logic [FRAME_W-1:0]    frame_r, frame_nxt;
  logic [TIME_W-1:0]     time_left_r, time_left_nxt;
  logic [PLAYS_W-1:0]    plays_r, plays_nxt;
  logic                  playing_r, playing_nxt;
  logic                  opcode_r;
  logic [TIME_W-1:0]     delta_r;
  logic [ADJ_W-1:0]      adj_r, adj_nxt;
  logic [DIVIDEND_W-1:0] rest_r, rest_nxt;
  logic [DIVIDEND_W-1:0] k_r, k_nxt;
  logic [TIME_W-1:0]     r1_r, r1_nxt;
  logic [LEN_W-1:0]      d1_r, d1_nxt, len_r, len_nxt;
  logic [FRAME_W-1:0]    before_r, before_nxt;
  end_event_t            ev_r, ev_nxt;
  logic                  out_valid_r;
  logic [OUT_USED_W-1:0] out_data_r;

  logic [TIME_W-1:0]     period;
  logic [PROD_W-1:0]     product;
  logic                  in_fire, emit_fire, out_busy;
  logic [DIVIDEND_W-1:0] wraps;
  logic [PLAYS_W-1:0]    done_at;
  logic                  finish;
  logic [FRAME_W-1:0]    wrap_off;

  // A zero period counts as one microsecond.
  assign period    = (frame_period_r == '0) ? TIME_W'(1) : frame_period_r;
  assign product   = speed_gain_r * delta_r;
  assign in_tready = op == OP_ACCEPT;
  assign in_fire   = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;
  assign emit_fire = (op == OP_EMIT) && !out_busy;

  assign div_start   = (op == OP_DIV_PERIOD) || (op == OP_DIV_RANGE);
  assign div_divisor = (op == OP_DIV_RANGE) ? DIVISOR_W'(len_r) : period;

  sfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rest_r),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Wrap count and the test for running out of plays.
  assign wraps    = div_quo + 1'b1;
  assign done_at  = (plays_r == '0) ? PLAYS_W'(1) : plays_r;
  assign finish   = !play_forever_r && (wraps >= DIVIDEND_W'(done_at));
  assign wrap_off = div_rem[FRAME_W-1:0];

  always_comb begin
    status.no_input   = !in_tvalid;
    status.restart    = opcode_r == OPC_RESTART;
    status.stopped    = !playing_r;
    status.short_tick = adj_r < ADJ_W'(time_left_r);
    status.div_busy   = div_busy;
    status.near       = k_r < DIVIDEND_W'(d1_r);
    status.out_busy   = out_busy;
  end

  // Datapath operations selected by the control word.
  always_comb begin
    frame_nxt     = frame_r;
    time_left_nxt = time_left_r;
    plays_nxt     = plays_r;
    playing_nxt   = playing_r;
    adj_nxt       = adj_r;
    rest_nxt      = rest_r;
    k_nxt         = k_r;
    r1_nxt        = r1_r;
    d1_nxt        = d1_r;
    len_nxt       = len_r;
    before_nxt    = before_r;
    ev_nxt        = ev_r;
    case (op)
      OP_MUL: begin
        adj_nxt    = product[PROD_W-1:GAIN_FRAC];
        before_nxt = frame_r;
        ev_nxt     = EV_NONE;
      end
      OP_SPEND: begin
        if (status.short_tick) begin
          time_left_nxt = time_left_r - adj_r[TIME_W-1:0];
        end else begin
          rest_nxt = {1'b0, adj_r} - DIVIDEND_W'(time_left_r);
        end
      end
      OP_STEPS: begin
        k_nxt  = div_quo + 1'b1;
        r1_nxt = div_rem;
        // Steps left before the next wrap, and the range length.
        if (!play_reverse_r) begin
          d1_nxt = (frame_r < end_frame_r) ?
                   LEN_W'(end_frame_r - frame_r) + 1'b1 : LEN_W'(1);
        end else begin
          d1_nxt = (frame_r > start_frame_r) ?
                   LEN_W'(frame_r - start_frame_r) + 1'b1 : LEN_W'(1);
        end
        len_nxt = (start_frame_r <= end_frame_r) ?
                  LEN_W'(end_frame_r - start_frame_r) + 1'b1 : LEN_W'(1);
      end
      OP_NEAR: begin
        if (status.near) begin
          frame_nxt     = play_reverse_r ? frame_r - k_r[FRAME_W-1:0] :
                                           frame_r + k_r[FRAME_W-1:0];
          time_left_nxt = period - r1_r;
        end else begin
          rest_nxt = k_r - DIVIDEND_W'(d1_r);
        end
      end
      OP_WRAP: begin
        if (finish) begin
          plays_nxt     = '0;
          playing_nxt   = 1'b0;
          frame_nxt     = play_reverse_r ? start_frame_r : end_frame_r;
          time_left_nxt = '0;
          ev_nxt        = play_reverse_r ? EV_BEGIN : EV_END;
        end else begin
          if (!play_forever_r) begin
            plays_nxt = plays_r - wraps[PLAYS_W-1:0];
          end
          frame_nxt     = play_reverse_r ? end_frame_r - wrap_off :
                                           start_frame_r + wrap_off;
          time_left_nxt = period - r1_r;
        end
      end
      OP_RESTART: begin
        frame_nxt     = play_reverse_r ? end_frame_r : start_frame_r;
        time_left_nxt = frame_period_r;
        plays_nxt     = play_count_r;
        playing_nxt   = 1'b1;
        ev_nxt        = EV_NONE;
      end
      default: ;
    endcase
  end

  // Playback state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= '0;
      time_left_r <= PERIOD_RESET;
      plays_r     <= PLAYS_RESET;
      playing_r   <= 1'b1;
    end else begin
      frame_r     <= frame_nxt;
      time_left_r <= time_left_nxt;
      plays_r     <= plays_nxt;
      playing_r   <= playing_nxt;
    end
  end

  // Working registers and the captured request.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      opcode_r <= in_tuser;
      delta_r  <= in_tdata[TIME_W-1:0];
    end
    adj_r    <= adj_nxt;
    rest_r   <= rest_nxt;
    k_r      <= k_nxt;
    r1_r     <= r1_nxt;
    d1_r     <= d1_nxt;
    len_r    <= len_nxt;
    before_r <= before_nxt;
    ev_r     <= ev_nxt;
  end

  // Output register; a pending result holds until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r <= {playing_r, ev_r, frame_r != before_r, frame_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), out_data_r};

endmodule

/* tb/sprite_frame_sequencer_test.sv */
`timescale 1ns / 1ps

module sprite_frame_sequencer_test;
  import sfs_pkg::*;

  // Result fields as they sit in out_tdata, highest field first.
  typedef struct packed {
    logic              is_playing;
    end_event_t        ev;
    logic              changed;
    logic [FRAME_W-1:0] frame;
  } frame_report_t;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

  // One line of the directed stimulus: a register write or a request.
  typedef struct packed {
    row_kind_t       kind;
    cfg_index_t      reg_idx;
    logic [31:0]     value;
    logic            opc;
    logic            typed;
    frame_report_t   want;
  } stim_row_t;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 100;
  localparam int ROWS = 39;

  // Directed stimulus. Rows with typed set carry a hand-written result;
  // the others are checked against the predictor.
  localparam stim_row_t DIRECTED [ROWS] = '{
    // Reset state: a single-frame range that ends on its first wrap.
    '{ROW_ITEM, CFG_START_FRAME, 32'd0, OPC_TICK, 1'b1, '{1'b1, EV_NONE, 1'b0, 16'd0}},
    '{ROW_ITEM, CFG_START_FRAME, 32'd16666, OPC_TICK, 1'b1, '{1'b1, EV_NONE, 1'b0, 16'd0}},
    '{ROW_ITEM, CFG_START_FRAME, 32'd1, OPC_TICK, 1'b1, '{1'b0, EV_END, 1'b0, 16'd0}},
    '{ROW_ITEM, CFG_START_FRAME, 32'hFFFF_FFFF, OPC_TICK, 1'b1,
      '{1'b0, EV_NONE, 1'b0, 16'd0}},
    '{ROW_ITEM, CFG_START_FRAME, 32'hFFFF_FFFF, OPC_RESTART, 1'b1,
      '{1'b1, EV_NONE, 1'b0, 16'd0}},
    // A short range with two plays, stepping upward.
    '{ROW_REG, CFG_START_FRAME, 32'd3, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_END_FRAME, 32'd7, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_FRAME_PERIOD, 32'd10, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_PLAY_COUNT, 32'd2, OPC_TICK, 1'b0, '0},
    '{ROW_ITEM, CFG_START_FRAME, 32'd0, OPC_RESTART, 1'b1, '{1'b1, EV_NONE, 1'b1, 16'd3}},
    '{ROW_ITEM, CFG_START_FRAME, 32'd25, OPC_TICK, 1'b0, '0},
    '{ROW_ITEM, CFG_START_FRAME, 32'd60, OPC_TICK, 1'b0, '0},
    '{ROW_ITEM, CFG_START_FRAME, 32'd100, OPC_TICK, 1'b0, '0},
    // Reverse, endless looping at full gain.
    '{ROW_REG, CFG_PLAY_REVERSE, 32'd1, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_PLAY_FOREVER, 32'd1, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_SPEED_GAIN, 32'd65535, OPC_TICK, 1'b0, '0},
    '{ROW_ITEM, CFG_START_FRAME, 32'd0, OPC_RESTART, 1'b1, '{1'b1, EV_NONE, 1'b0, 16'd7}},
    '{ROW_ITEM, CFG_START_FRAME, 32'hFFFF_FFFF, OPC_TICK, 1'b0, '0},
    '{ROW_ITEM, CFG_START_FRAME, 32'd3, OPC_TICK, 1'b0, '0},
    // Zero gain freezes time.
    '{ROW_REG, CFG_SPEED_GAIN, 32'd0, OPC_TICK, 1'b0, '0},
    '{ROW_ITEM, CFG_START_FRAME, 32'hFFFF_FFFF, OPC_TICK, 1'b0, '0},
    // Zero play count and zero period, reaching the beginning.
    '{ROW_REG, CFG_PLAY_FOREVER, 32'd0, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_PLAY_COUNT, 32'd0, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_SPEED_GAIN, 32'd256, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_FRAME_PERIOD, 32'd0, OPC_TICK, 1'b0, '0},
    '{ROW_ITEM, CFG_START_FRAME, 32'd0, OPC_RESTART, 1'b0, '0},
    '{ROW_ITEM, CFG_START_FRAME, 32'd1, OPC_TICK, 1'b0, '0},
    '{ROW_ITEM, CFG_START_FRAME, 32'd10, OPC_TICK, 1'b0, '0},
    // Inverted range with the longest period and the most plays.
    '{ROW_REG, CFG_START_FRAME, 32'd65535, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_END_FRAME, 32'd0, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_PLAY_REVERSE, 32'd0, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_FRAME_PERIOD, 32'hFFFF_FFFF, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_PLAY_COUNT, 32'd65535, OPC_TICK, 1'b0, '0},
    '{ROW_ITEM, CFG_START_FRAME, 32'd0, OPC_RESTART, 1'b1,
      '{1'b1, EV_NONE, 1'b1, 16'hFFFF}},
    '{ROW_ITEM, CFG_START_FRAME, 32'hFFFF_FFFF, OPC_TICK, 1'b0, '0},
    // Full range.
    '{ROW_REG, CFG_START_FRAME, 32'd0, OPC_TICK, 1'b0, '0},
    '{ROW_REG, CFG_END_FRAME, 32'd65535, OPC_TICK, 1'b0, '0},
    '{ROW_ITEM, CFG_START_FRAME, 32'd0, OPC_RESTART, 1'b1, '{1'b1, EV_NONE, 1'b1, 16'd0}},
    '{ROW_ITEM, CFG_START_FRAME, 32'hFFFF_FFFF, OPC_TICK, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_FRAME;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [31:0] delta_time
  logic                  in_tuser = OPC_TICK;   // [0] opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [15:0] frame_index, [16] frame_changed, [18:17] end_event, [19] is_playing
  logic [OUT_DATA_W-1:0] out_tdata;

  sprite_frame_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies and sequencer state of the predictor.
  logic [FRAME_W-1:0] reg_start, reg_end;
  logic [TIME_W-1:0]  reg_period;
  logic [GAIN_W-1:0]  reg_gain;
  logic               reg_reverse, reg_forever;
  logic [PLAYS_W-1:0] reg_count;
  logic [FRAME_W-1:0] cur_frame;
  logic [TIME_W-1:0]  time_left;
  logic [PLAYS_W-1:0] plays_left;
  bit                 running;

  frame_report_t frame_reports_due [$];
  int errors = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int requests_sent = 0;
  int restarts_sent = 0;
  int results_checked = 0;
  int end_events_seen = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  // Moves the frame k steps through the range; returns 1 when play finishes.
  function automatic bit step_frames(input longint unsigned k);
    longint unsigned f, s, e, span, d1, wraps, rem, done_at;
    f = cur_frame;
    s = reg_start;
    e = reg_end;
    span = (s <= e) ? e - s + 1 : 1;
    if (!reg_reverse) d1 = (f < e) ? e - f + 1 : 1;
    else d1 = (f > s) ? f - s + 1 : 1;
    if (k < d1) begin
      cur_frame = reg_reverse ? 16'(f - k) : 16'(f + k);
      return 1'b0;
    end
    wraps = 1 + (k - d1) / span;
    rem = (k - d1) % span;
    if (!reg_forever) begin
      done_at = (plays_left == 0) ? 1 : plays_left;
      if (wraps >= done_at) begin
        plays_left = '0;
        running = 1'b0;
        cur_frame = reg_reverse ? reg_start : reg_end;
        return 1'b1;
      end
      plays_left = 16'(plays_left - wraps);
    end
    cur_frame = reg_reverse ? 16'(e - rem) : 16'(s + rem);
    return 1'b0;
  endfunction

  // Applies one request to the predictor state and returns its result.
  function automatic frame_report_t play_request(input logic opc,
                                                 input logic [31:0] delta);
    frame_report_t r;
    logic [FRAME_W-1:0] prior;
    end_event_t ev;
    longint unsigned scaled, per;
    prior = cur_frame;
    ev = EV_NONE;
    if (opc == OPC_RESTART) begin
      cur_frame = reg_reverse ? reg_end : reg_start;
      time_left = reg_period;
      plays_left = reg_count;
      running = 1'b1;
    end else if (running) begin
      scaled = (longint'(reg_gain) * longint'(delta)) >> GAIN_FRAC;
      if (scaled < time_left) begin
        time_left = 32'(scaled == 0 ? time_left : time_left - scaled);
      end else begin
        per = (reg_period == 0) ? 1 : reg_period;
        scaled = scaled - time_left;
        if (step_frames(1 + scaled / per)) begin
          time_left = '0;
          ev = reg_reverse ? EV_BEGIN : EV_END;
        end else begin
          time_left = 32'(per - scaled % per);
        end
      end
    end
    r.frame = cur_frame;
    r.changed = (cur_frame != prior);
    r.ev = ev;
    r.is_playing = running;
    return r;
  endfunction

  task automatic note_error(input string msg);
    if (errors < 10) $display("%s", msg);
    errors++;
  endtask

  // Waits for the block to go idle, then writes one register.
  task automatic write_setting(input cfg_index_t idx, input logic [31:0] value);
    in_tvalid <= 1'b0;
    while (frame_reports_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_START_FRAME:  reg_start = value[FRAME_W-1:0];
      CFG_END_FRAME:    reg_end = value[FRAME_W-1:0];
      CFG_FRAME_PERIOD: reg_period = value;
      CFG_SPEED_GAIN:   reg_gain = value[GAIN_W-1:0];
      CFG_PLAY_REVERSE: reg_reverse = value[0];
      CFG_PLAY_COUNT:   reg_count = value[PLAYS_W-1:0];
      CFG_PLAY_FOREVER: reg_forever = value[0];
      default: ;
    endcase
  endtask

  // Offers one request, waits for it to be taken and records its result.
  task automatic issue_request(input logic opc, input logic [31:0] delta,
                               input logic typed, input frame_report_t want);
    frame_report_t predicted;
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= opc;
    in_tdata <= delta;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = play_request(opc, delta);
    if (typed) predicted = want;
    frame_reports_due = {frame_reports_due, predicted};
    requests_sent++;
    if (opc == OPC_RESTART) restarts_sent++;
  endtask

  // Receiver stalls.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    frame_report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = frame_report_t'(out_tdata[OUT_USED_W-1:0]);
      if (frame_reports_due.size() == 0) begin
        note_error($sformatf("unexpected result: frame %0d changed %0d event %0d playing %0d",
                             got.frame, got.changed, got.ev, got.is_playing));
      end else begin
        want = frame_reports_due.pop_front();
        results_checked++;
        if (got.ev != EV_NONE) end_events_seen++;
        if (got.frame != want.frame || got.changed != want.changed ||
            got.ev != want.ev || got.is_playing != want.is_playing) begin
          note_error($sformatf({"result %0d mismatch: expected frame %0d changed %0d ",
                                "event %0d playing %0d, got frame %0d changed %0d ",
                                "event %0d playing %0d"},
                               results_checked, want.frame, want.changed, want.ev,
                               want.is_playing, got.frame, got.changed, got.ev,
                               got.is_playing));
        end
      end
    end
  end

  // Watchdog on handshake activity.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("sprite_frame_sequencer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int counted;
    int pick;
    logic opc;
    logic [31:0] delta;
    logic [FRAME_W-1:0] first, last;
    logic [31:0] period_pick;
    longint unsigned per, aim;

    // Predictor state after reset.
    reg_start = '0;
    reg_end = '0;
    reg_period = PERIOD_RESET;
    reg_gain = GAIN_RESET;
    reg_reverse = 1'b0;
    reg_count = PLAYS_RESET;
    reg_forever = 1'b0;
    cur_frame = '0;
    time_left = PERIOD_RESET;
    plays_left = PLAYS_RESET;
    running = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    for (int i = 0; i < ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        write_setting(DIRECTED[i].reg_idx, DIRECTED[i].value);
      end else begin
        issue_request(DIRECTED[i].opc, DIRECTED[i].value, DIRECTED[i].typed,
                      DIRECTED[i].want);
      end
    end

    // Random phases, each with fresh settings and one of four idling patterns.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 58; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 58; end
        default: begin send_gap_pct = 38; recv_stall_pct = 38; end
      endcase

      // Frame range: mostly short ranges, sometimes full, single-frame or inverted.
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin first = '0; last = '1; end
        1: begin first = '1; last = '0; end
        2: begin first = 16'($urandom_range(0, 65535)); last = 16'($urandom_range(0, first)); end
        3: begin first = 16'($urandom_range(0, 65535)); last = first; end
        default: begin
          first = 16'($urandom_range(0, 65520));
          last = first + 16'($urandom_range(1, 12));
        end
      endcase
      pick = $urandom_range(0, 19);
      case (pick)
        0: period_pick = 32'd1;
        1: period_pick = '1;
        2: period_pick = $urandom();
        3: period_pick = '0;
        default: period_pick = $urandom_range(1, 300);
      endcase
      write_setting(CFG_START_FRAME, {16'd0, first});
      write_setting(CFG_END_FRAME, {16'd0, last});
      write_setting(CFG_FRAME_PERIOD, period_pick);
      pick = $urandom_range(0, 9);
      write_setting(CFG_SPEED_GAIN, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd65535 :
                    (pick == 2) ? $urandom_range(0, 65535) : $urandom_range(32, 1024));
      write_setting(CFG_PLAY_REVERSE, $urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      write_setting(CFG_PLAY_COUNT, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd65535 :
                    $urandom_range(1, 4));
      write_setting(CFG_PLAY_FOREVER, 32'($urandom_range(0, 4) == 0));
      settings_used++;

      counted = 0;
      while (counted < PHASE_ITEMS) begin
        // Restarts come often once play has stopped, rarely while playing.
        if (running) opc = ($urandom_range(0, 19) == 0) ? OPC_RESTART : OPC_TICK;
        else opc = ($urandom_range(0, 3) != 0) ? OPC_RESTART : OPC_TICK;

        // Tick lengths mostly cover a few frame periods at the current gain.
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          delta = '0;
        end else if (pick == 1 || reg_gain == 0) begin
          delta = $urandom();
        end else if (pick == 2) begin
          delta = '1;
        end else begin
          per = (reg_period == 0) ? 1 : reg_period;
          aim = per * $urandom_range(0, 5) + $urandom_range(0, reg_period);
          aim = (aim << GAIN_FRAC) / reg_gain;
          delta = (aim > 64'hFFFF_FFFF) ? '1 : 32'(aim);
        end

        if (opc == OPC_RESTART || running) counted++;
        issue_request(opc, delta, 1'b0, '0);
      end
    end

    // Drain.
    in_tvalid <= 1'b0;
    while (frame_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_reports_due.size() != 0) note_error("results still outstanding at the end");

    $display("Sent %0d requests (%0d restarts) across %0d random settings plus directed rows.",
             requests_sent, restarts_sent, settings_used);
    $display("Checked %0d results, %0d of them with an end event; %0d errors.",
             results_checked, end_events_seen, errors);
    if (errors == 0) begin
      $display("sprite_frame_sequencer test passed");
    end else begin
      $display("sprite_frame_sequencer test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/sfs_pkg.sv
rtl/core/sfs_div.sv
rtl/core/sfs_seq.sv
rtl/core/sprite_frame_sequencer.sv
tb/sprite_frame_sequencer_test.sv
